FILE: src/pcfc_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and constants of the pulsing colour fade controller
// includes the sine pulse factor table builder; no dependencies

package pcfc_pkg;

    localparam int TIME_BITS_DEF = 16;
    localparam int SINE_SIZE     = 256;
    localparam int SINE_BITS     = $clog2(SINE_SIZE);
    localparam int ST_BITS       = 15;
    localparam int Q_BITS        = 14;
    localparam int GREY_SHIFT    = 21;
    localparam int LVL_STEPS     = 9;
    localparam int PADDR_W       = 5;

    localparam logic [1:0] OP_TICK       = 2'd0;
    localparam logic [1:0] OP_ACTIVATE   = 2'd1;
    localparam logic [1:0] OP_DEACTIVATE = 2'd2;

    localparam logic [1:0] MODE_INACTIVE = 2'd0;
    localparam logic [1:0] MODE_FADE_IN  = 2'd1;
    localparam logic [1:0] MODE_ACTIVE   = 2'd2;
    localparam logic [1:0] MODE_FADE_OUT = 2'd3;

    localparam logic [2:0] REG_LOW_COLOR    = 3'd0;
    localparam logic [2:0] REG_HIGH_COLOR   = 3'd1;
    localparam logic [2:0] REG_FADE_IN_LEN  = 3'd2;
    localparam logic [2:0] REG_FADE_OUT_LEN = 3'd3;
    localparam logic [2:0] REG_PULSE_PERIOD = 3'd4;

    localparam logic [23:0] LOW_COLOR_RST  = 24'h404040;
    localparam logic [23:0] HIGH_COLOR_RST = 24'h808080;
    localparam logic [15:0] FADE_LEN_RST   = 16'd2000;
    localparam logic [15:0] PERIOD_RST     = 16'd3000;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] elapsed_ticks;
    } t_in_item;

    typedef struct packed {
        logic       light_enable;
        logic [7:0] red_level;
        logic [7:0] green_level;
        logic [7:0] blue_level;
    } t_out_item;

    typedef struct packed {
        logic [23:0] low_color;
        logic [23:0] high_color;
        logic [15:0] fade_in_length;
        logic [15:0] fade_out_length;
        logic [15:0] pulse_period;
    } t_cfg;

    typedef struct packed {
        logic       capture;
        logic       start_fade;
        logic [1:0] new_mode;
        logic       fade_adv;
        logic       rev_mul;
        logic       rev_load;
        logic       rev_end;
        logic       phase_load;
        logic       div_step;
        logic       wave_cap;
        logic       k_set;
        logic       rom_rd;
        logic       blend_setup;
        logic       ch_mul1;
        logic       ch_add;
        logic       ch_mul2;
        logic       ch_num;
        logic       lv_step;
        logic       ch_store;
        logic [1:0] ch;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic [1:0] mode;
        logic       rev_zero;
        logic       p_zero;
        logic       out_free;
    } t_status;

    typedef logic [ST_BITS-1:0] t_st_rom [SINE_SIZE];

    // pulse factor 1 + sin/2 in q14 for one table index
    function automatic logic [ST_BITS-1:0] st_of_k(input int unsigned k);
        longint unsigned f, x, x2, x3, x5, x7, x9, pos, neg, m;
        longint unsigned quad;
        f    = (longint'(k) << 16) >> SINE_BITS;
        quad = (f >> 14) & 64'd3;
        x    = f & 64'h3FFF;
        if ((quad & 64'd1) != 0)
            x = 64'd16384 - x;
        x2  = (x * x) >> 14;
        x3  = (x2 * x) >> 14;
        x5  = (x3 * x2) >> 14;
        x7  = (x5 * x2) >> 14;
        x9  = (x7 * x2) >> 14;
        pos = 64'd1686629713 * x + 64'd85569305 * x5 + 64'd172272 * x9;
        neg = 64'd693598666 * x3 + 64'd5026995 * x7;
        m   = (pos > neg) ? ((pos - neg) >> 30) : 64'd0;
        if (m > 64'd16384)
            m = 64'd16384;
        if (quad >= 64'd2)
            return ST_BITS'(64'd16384 - (m >> 1));
        return ST_BITS'(64'd16384 + (m >> 1));
    endfunction

    function automatic t_st_rom build_st_rom();
        t_st_rom rom;
        for (int i = 0; i < SINE_SIZE; i++)
            rom[i] = st_of_k(i);
        return rom;
    endfunction

endpackage

FILE: src/pcfc_div.sv
`timescale 1ns / 1ps
// restoring divider, one quotient bit per step, shared by phase and reversal work
// no package dependencies

module pcfc_div #(
    parameter int NW = 41,
    parameter int DW = 16
) (
    input  logic          i_clk,
    input  logic          i_load,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic          i_step,
    output logic [DW:0]   o_rem,
    output logic [NW-1:0] o_quo
);

    logic [NW-1:0] r_num;
    logic [DW-1:0] r_den;
    logic [DW:0]   r_rem;
    logic [NW-1:0] r_quo;
    logic [DW:0]   shifted;
    logic          ge;
    logic [DW:0]   n_rem;

    assign shifted = {r_rem[DW-1:0], r_num[NW-1]};
    assign ge      = shifted >= {1'b0, r_den};
    assign n_rem   = ge ? (shifted - {1'b0, r_den}) : shifted;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= '0;
        end else if (i_step) begin
            r_num <= {r_num[NW-2:0], 1'b0};
            r_rem <= n_rem;
            r_quo <= {r_quo[NW-2:0], ge};
        end
    end

    assign o_rem = r_rem;
    assign o_quo = r_quo;

endmodule

FILE: src/pcfc_ctrl.sv
`timescale 1ns / 1ps
// sequencer of the pulsing colour fade controller
// uses pcfc_pkg for codes and the command and status structs

module pcfc_ctrl import pcfc_pkg::*; #(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam int CNTW = $clog2(2 * TIME_BITS);

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_DECODE   = 5'd1;
    localparam logic [4:0] S_REV_MUL  = 5'd2;
    localparam logic [4:0] S_REV_LOAD = 5'd3;
    localparam logic [4:0] S_REV_DIV  = 5'd4;
    localparam logic [4:0] S_REV_END  = 5'd5;
    localparam logic [4:0] S_PHASE    = 5'd6;
    localparam logic [4:0] S_MOD      = 5'd7;
    localparam logic [4:0] S_CAPT     = 5'd8;
    localparam logic [4:0] S_FRAC     = 5'd9;
    localparam logic [4:0] S_KSET     = 5'd10;
    localparam logic [4:0] S_ROM      = 5'd11;
    localparam logic [4:0] S_SETUP    = 5'd12;
    localparam logic [4:0] S_CH_MUL1  = 5'd13;
    localparam logic [4:0] S_CH_ADD   = 5'd14;
    localparam logic [4:0] S_CH_MUL2  = 5'd15;
    localparam logic [4:0] S_CH_NUM   = 5'd16;
    localparam logic [4:0] S_CH_DIV   = 5'd17;
    localparam logic [4:0] S_CH_STORE = 5'd18;
    localparam logic [4:0] S_OUT      = 5'd19;

    logic [4:0]      r_state, n_state;
    logic [CNTW-1:0] r_cnt, n_cnt;
    logic [1:0]      r_ch, n_ch;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_ch     = r_ch;
        o_cmd    = '0;
        o_cmd.ch = r_ch;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_IDLE;
                case (i_status.op)
                    OP_TICK: begin
                        if (i_status.mode == MODE_INACTIVE) begin
                            n_state = S_OUT;
                        end else begin
                            o_cmd.fade_adv = 1'b1;
                            n_state        = S_PHASE;
                        end
                    end
                    OP_ACTIVATE: begin
                        if (i_status.mode == MODE_INACTIVE) begin
                            o_cmd.start_fade = 1'b1;
                            o_cmd.new_mode   = MODE_FADE_IN;
                        end else if (i_status.mode == MODE_FADE_OUT) begin
                            n_state = S_REV_MUL;
                        end
                    end
                    OP_DEACTIVATE: begin
                        if (i_status.mode == MODE_ACTIVE) begin
                            o_cmd.start_fade = 1'b1;
                            o_cmd.new_mode   = MODE_FADE_OUT;
                        end else if (i_status.mode == MODE_FADE_IN) begin
                            n_state = S_REV_MUL;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_REV_MUL: begin
                o_cmd.rev_mul = 1'b1;
                n_state       = i_status.rev_zero ? S_REV_END : S_REV_LOAD;
            end
            S_REV_LOAD: begin
                o_cmd.rev_load = 1'b1;
                n_cnt          = CNTW'(2 * TIME_BITS - 1);
                n_state        = S_REV_DIV;
            end
            S_REV_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt - 1'b1;
                if (r_cnt == '0)
                    n_state = S_REV_END;
            end
            S_REV_END: begin
                o_cmd.rev_end = 1'b1;
                n_state       = S_IDLE;
            end
            S_PHASE: begin
                o_cmd.phase_load = 1'b1;
                n_cnt            = CNTW'(TIME_BITS);
                n_state          = i_status.p_zero ? S_ROM : S_MOD;
            end
            S_MOD: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt - 1'b1;
                if (r_cnt == '0)
                    n_state = S_CAPT;
            end
            S_CAPT: begin
                o_cmd.wave_cap = 1'b1;
                n_cnt          = CNTW'(SINE_BITS - 1);
                n_state        = S_FRAC;
            end
            S_FRAC: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt - 1'b1;
                if (r_cnt == '0)
                    n_state = S_KSET;
            end
            S_KSET: begin
                o_cmd.k_set = 1'b1;
                n_state     = S_ROM;
            end
            S_ROM: begin
                o_cmd.rom_rd = 1'b1;
                n_state      = S_SETUP;
            end
            S_SETUP: begin
                o_cmd.blend_setup = 1'b1;
                n_ch              = 2'd0;
                // a fade-out that just ended gives a dark result
                n_state = (i_status.mode == MODE_INACTIVE) ? S_OUT : S_CH_MUL1;
            end
            S_CH_MUL1: begin
                o_cmd.ch_mul1 = 1'b1;
                n_state       = S_CH_ADD;
            end
            S_CH_ADD: begin
                o_cmd.ch_add = 1'b1;
                n_state      = S_CH_MUL2;
            end
            S_CH_MUL2: begin
                o_cmd.ch_mul2 = 1'b1;
                n_state       = S_CH_NUM;
            end
            S_CH_NUM: begin
                o_cmd.ch_num = 1'b1;
                n_cnt        = CNTW'(LVL_STEPS - 1);
                n_state      = S_CH_DIV;
            end
            S_CH_DIV: begin
                o_cmd.lv_step = 1'b1;
                n_cnt         = r_cnt - 1'b1;
                if (r_cnt == '0)
                    n_state = S_CH_STORE;
            end
            S_CH_STORE: begin
                o_cmd.ch_store = 1'b1;
                if (r_ch == 2'd2) begin
                    n_state = S_OUT;
                end else begin
                    n_ch    = r_ch + 2'd1;
                    n_state = S_CH_MUL1;
                end
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_ch    <= 2'd0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ch    <= n_ch;
        end
    end

endmodule

FILE: src/pcfc_dp.sv
`timescale 1ns / 1ps
// datapath: mode and time state, phase, sine table, colour blend and result register
// uses pcfc_pkg and pcfc_div

module pcfc_dp import pcfc_pkg::*; #(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  t_in_item  i_in_item,
    input  t_cmd      i_cmd,
    output t_status   o_status,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    localparam int TB = TIME_BITS;
    localparam int AW = TB + 1;
    localparam int NW = 2 * TB + SINE_BITS;
    localparam int CW = 26;
    localparam int PW = 25;
    localparam int LW = TB + 28;
    localparam t_st_rom ST_ROM = build_st_rom();

    logic [1:0]           r_op;
    logic [TB-1:0]        r_dt;
    logic [1:0]           r_mode;
    logic [AW-1:0]        r_e;
    logic [AW-1:0]        r_wave;
    logic [SINE_BITS-1:0] r_k;
    logic [ST_BITS-1:0]   r_st;
    logic [2*TB-1:0]      r_prod;
    logic [TB-1:0]        r_a, r_b, r_l;
    logic signed [PW-1:0] r_p1;
    logic signed [CW-1:0] r_c;
    logic signed [LW-1:0] r_p2;
    logic [LW-1:0]        r_lrem, r_ld;
    logic [LVL_STEPS-1:0] r_lq;
    logic                 r_neg;
    logic [7:0]           r_red, r_green, r_blue;
    logic                 r_out_valid;
    t_out_item            r_out;

    logic [TB-1:0]        fi, fo, period, dt_in;
    logic [TB-1:0]        from_len, to_len, from_ecap, len, len_ecap;
    logic [AW:0]          e_add, w_add;
    logic [AW-1:0]        e_sum, w_sum;
    logic                 in_fade, blend;
    logic [7:0]           ch_lo, ch_hi;
    logic signed [8:0]    ch_diff;
    logic signed [LW-1:0] lv_num;
    logic                 lv_ge;
    logic [7:0]           lvl;
    logic                 div_load;
    logic [NW-1:0]        div_num;
    logic [TB-1:0]        div_den;
    logic [AW-1:0]        div_rem;
    logic [NW-1:0]        div_quo;

    assign fi     = TB'(i_cfg.fade_in_length);
    assign fo     = TB'(i_cfg.fade_out_length);
    assign period = TB'(i_cfg.pulse_period);
    assign dt_in  = TB'(i_in_item.elapsed_ticks);

    // saturating time accumulators
    assign e_add = {1'b0, r_e} + (AW+1)'(r_dt);
    assign e_sum = e_add[AW] ? '1 : e_add[AW-1:0];
    assign w_add = {1'b0, r_wave} + (AW+1)'(r_dt);
    assign w_sum = w_add[AW] ? '1 : w_add[AW-1:0];

    assign from_len  = (r_mode == MODE_FADE_OUT) ? fo : fi;
    assign to_len    = (r_mode == MODE_FADE_OUT) ? fi : fo;
    assign from_ecap = (r_e > {1'b0, from_len}) ? from_len : r_e[TB-1:0];
    assign len       = (r_mode == MODE_FADE_IN) ? fi : fo;
    assign len_ecap  = (r_e > {1'b0, len}) ? len : r_e[TB-1:0];
    assign in_fade   = (r_mode == MODE_FADE_IN) || (r_mode == MODE_FADE_OUT);
    assign blend     = in_fade && (len != '0);

    always_comb begin
        case (i_cmd.ch)
            2'd0: begin
                ch_lo = i_cfg.low_color[23:16];
                ch_hi = i_cfg.high_color[23:16];
            end
            2'd1: begin
                ch_lo = i_cfg.low_color[15:8];
                ch_hi = i_cfg.high_color[15:8];
            end
            default: begin
                ch_lo = i_cfg.low_color[7:0];
                ch_hi = i_cfg.high_color[7:0];
            end
        endcase
    end

    assign ch_diff = $signed({1'b0, ch_hi}) - $signed({1'b0, ch_lo});
    assign lv_num  = r_p2 + $signed(LW'({r_b, {GREY_SHIFT{1'b0}}}));
    assign lv_ge   = r_lrem >= r_ld;

    always_comb begin
        if (r_neg)
            lvl = 8'd0;
        else if (r_lq[LVL_STEPS-1])
            lvl = 8'hFF;
        else
            lvl = r_lq[7:0];
    end

    assign div_load = i_cmd.rev_load || (i_cmd.phase_load && (period != '0));
    assign div_num  = i_cmd.rev_load ? {r_prod, {SINE_BITS{1'b0}}}
                                     : {w_sum, {(NW-AW){1'b0}}};
    assign div_den  = i_cmd.rev_load ? from_len : period;

    pcfc_div #(
        .NW (NW),
        .DW (TB)
    ) u_div (
        .i_clk  (i_clk),
        .i_load (div_load),
        .i_num  (div_num),
        .i_den  (div_den),
        .i_step (i_cmd.div_step),
        .o_rem  (div_rem),
        .o_quo  (div_quo)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_INACTIVE;
            r_e         <= '0;
            r_wave      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.start_fade) begin
                r_mode <= i_cmd.new_mode;
                r_e    <= '0;
            end
            if (i_cmd.fade_adv) begin
                if (r_mode == MODE_FADE_IN) begin
                    r_e <= e_sum;
                    if ((fi == '0) || (e_sum > {1'b0, fi}))
                        r_mode <= MODE_ACTIVE;
                end else if (r_mode == MODE_FADE_OUT) begin
                    r_e <= e_sum;
                    if ((fo == '0) || (e_sum > {1'b0, fo}))
                        r_mode <= MODE_INACTIVE;
                end
            end
            if (i_cmd.rev_end) begin
                r_mode <= (r_mode == MODE_FADE_OUT) ? MODE_FADE_IN : MODE_FADE_OUT;
                r_e    <= (from_len == '0) ? '0 : AW'(div_quo[TB-1:0]);
            end
            if (i_cmd.phase_load)
                r_wave <= (period == '0) ? '0 : w_sum;
            // the phase wraps only when it passes the period
            if (i_cmd.wave_cap && (r_wave > {1'b0, period}))
                r_wave <= div_rem;
            if (i_cmd.out_load)
                r_out_valid <= 1'b1;
            else if (i_out_ready)
                r_out_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op <= i_in_item.operation;
            r_dt <= dt_in;
        end
        if (i_cmd.rev_mul)
            r_prod <= (from_len - from_ecap) * to_len;
        if (i_cmd.phase_load && (period == '0))
            r_k <= '0;
        if (i_cmd.k_set)
            r_k <= div_quo[SINE_BITS-1:0];
        if (i_cmd.rom_rd)
            r_st <= ST_ROM[r_k];
        if (i_cmd.blend_setup) begin
            if (blend) begin
                r_a <= (r_mode == MODE_FADE_IN) ? len_ecap : (len - len_ecap);
                r_b <= (r_mode == MODE_FADE_IN) ? (len - len_ecap) : len_ecap;
                r_l <= len;
            end else begin
                r_a <= TB'(1);
                r_b <= '0;
                r_l <= TB'(1);
            end
        end
        if (i_cmd.ch_mul1)
            r_p1 <= $signed({1'b0, r_st}) * ch_diff;
        if (i_cmd.ch_add)
            r_c <= $signed({{(CW-8-Q_BITS){1'b0}}, ch_lo, {Q_BITS{1'b0}}}) + CW'(r_p1);
        if (i_cmd.ch_mul2)
            r_p2 <= r_c * $signed({1'b0, r_a});
        if (i_cmd.ch_num) begin
            r_neg  <= lv_num[LW-1];
            r_lrem <= lv_num;
            r_ld   <= LW'({r_l, {(Q_BITS + LVL_STEPS - 1){1'b0}}});
            r_lq   <= '0;
        end
        if (i_cmd.lv_step) begin
            if (lv_ge)
                r_lrem <= r_lrem - r_ld;
            r_lq <= {r_lq[LVL_STEPS-2:0], lv_ge};
            r_ld <= r_ld >> 1;
        end
        if (i_cmd.ch_store) begin
            case (i_cmd.ch)
                2'd0:    r_red   <= lvl;
                2'd1:    r_green <= lvl;
                default: r_blue  <= lvl;
            endcase
        end
        if (i_cmd.out_load) begin
            r_out.light_enable <= (r_mode != MODE_INACTIVE);
            r_out.red_level    <= (r_mode != MODE_INACTIVE) ? r_red : 8'd0;
            r_out.green_level  <= (r_mode != MODE_INACTIVE) ? r_green : 8'd0;
            r_out.blue_level   <= (r_mode != MODE_INACTIVE) ? r_blue : 8'd0;
        end
    end

    assign o_status.op       = r_op;
    assign o_status.mode     = r_mode;
    assign o_status.rev_zero = (from_len == '0);
    assign o_status.p_zero   = (period == '0);
    assign o_status.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

FILE: src/pulsing_color_fade_controller_unit.sv
`timescale 1ns / 1ps
// Pulsing colour fade controller. Items are taken one at a time. For a tick item the
// phase goes through a shared restoring divider one bit a cycle (TIME_BITS + 1 steps
// for the wrap, 8 for the sine index) unless the period is zero, then each of the three
// colour channels is worked out in turn, most of the work in a 9-step level divider.
// A tick while inactive gives its dark result without the phase and colour work.
// Activate and deactivate start a fade or, when a fade is reversed, rescale the elapsed
// time through the divider. Results wait in an output register; configuration is to be
// written through the APB port only while idle, which the block itself does not enforce.

module pulsing_color_fade_controller_unit import pcfc_pkg::*; #(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in_item           i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_item          o_out_item
);

    localparam logic [15:0] LEN_MASK = (TIME_BITS >= 16) ? 16'hFFFF
                                     : 16'((32'd1 << TIME_BITS) - 32'd1);

    logic [23:0] r_low, r_high;
    logic [15:0] r_fade_in, r_fade_out, r_period;
    logic        wr_en;
    t_cfg        cfg;
    t_cmd        cmd;
    t_status     status;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low      <= LOW_COLOR_RST;
            r_high     <= HIGH_COLOR_RST;
            r_fade_in  <= FADE_LEN_RST & LEN_MASK;
            r_fade_out <= FADE_LEN_RST & LEN_MASK;
            r_period   <= PERIOD_RST & LEN_MASK;
        end else if (wr_en) begin
            case (paddr[4:2])
                REG_LOW_COLOR:    r_low      <= pwdata[23:0];
                REG_HIGH_COLOR:   r_high     <= pwdata[23:0];
                REG_FADE_IN_LEN:  r_fade_in  <= pwdata[15:0] & LEN_MASK;
                REG_FADE_OUT_LEN: r_fade_out <= pwdata[15:0] & LEN_MASK;
                REG_PULSE_PERIOD: r_period   <= pwdata[15:0] & LEN_MASK;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_LOW_COLOR:    prdata = {8'd0, r_low};
            REG_HIGH_COLOR:   prdata = {8'd0, r_high};
            REG_FADE_IN_LEN:  prdata = {16'd0, r_fade_in};
            REG_FADE_OUT_LEN: prdata = {16'd0, r_fade_out};
            REG_PULSE_PERIOD: prdata = {16'd0, r_period};
            default:          prdata = 32'd0;
        endcase
    end

    assign cfg.low_color       = r_low;
    assign cfg.high_color      = r_high;
    assign cfg.fade_in_length  = r_fade_in;
    assign cfg.fade_out_length = r_fade_out;
    assign cfg.pulse_period    = r_period;

    pcfc_ctrl #(
        .TIME_BITS (TIME_BITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    pcfc_dp #(
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

FILE: src/pcfc_checker.sv
`timescale 1ns / 1ps
// port-level checks of the pulsing colour fade controller, bound to the top level
// uses pcfc_pkg for the item types

module pcfc_checker import pcfc_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_item  i_in_item,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_item
);

    // a result held back by the sink stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped before transfer");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_item))
        else $error("result changed while stalled");

    // an offered input item waits unchanged until its transfer
    a_in_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in_item))
        else $error("input item withdrawn or changed before transfer");

    // dark result carries no colour
    a_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.light_enable |->
            (o_out_item.red_level == 8'd0) && (o_out_item.green_level == 8'd0)
            && (o_out_item.blue_level == 8'd0))
        else $error("dark result with colour");

    // one item at a time: an input transfer closes the input side
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken while busy");

endmodule

bind pulsing_color_fade_controller_unit pcfc_checker u_pcfc_checker (.*);
